/* design/opeval_pkg.sv */
package opeval_pkg;

  localparam int MAX_DEGREE_DEF = 16;
  localparam int STEP_W = 3;

  localparam logic [2:0] FAM_LEGENDRE = 3'd0;
  localparam logic [2:0] FAM_LAGUERRE = 3'd1;
  localparam logic [2:0] FAM_HERMITE  = 3'd2;
  localparam logic [2:0] FAM_CHEB1    = 3'd3;
  localparam logic [2:0] FAM_CHEB2    = 3'd4;

  localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_SUB,
    UOP_NEXT
  } uop_kind_t;

  typedef enum logic [2:0] {
    SRC_CUR,
    SRC_PREV,
    SRC_XP,
    SRC_TA,
    SRC_TB
  } src_t;

  typedef enum logic [2:0] {
    COEF_X,
    COEF_2KP1,
    COEF_K,
    COEF_KK,
    COEF_TWO,
    COEF_2K,
    COEF_RECIP
  } coef_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_24,
    SH_32
  } shift_t;

  typedef enum logic [1:0] {
    DST_XP,
    DST_TA,
    DST_TB
  } dest_t;

  typedef struct packed {
    uop_kind_t kind;
    src_t      src_a;
    src_t      src_b;
    coef_t     coef;
    shift_t    shift;
    dest_t     dest;
  } uop_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic mul_wr;
    logic sub_en;
    logic adv;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    uop_kind_t kind;
    logic      loop_done;
    logic      mul_done;
    logic      out_free;
  } sts_t;

  function automatic uop_t mk_mul(src_t src, coef_t coef, shift_t sh, dest_t dst);
    uop_t u;
    u.kind  = UOP_MUL;
    u.src_a = src;
    u.src_b = SRC_TB;
    u.coef  = coef;
    u.shift = sh;
    u.dest  = dst;
    return u;
  endfunction

  function automatic uop_t mk_sub(src_t a, src_t b);
    uop_t u;
    u.kind  = UOP_SUB;
    u.src_a = a;
    u.src_b = b;
    u.coef  = COEF_X;
    u.shift = SH_0;
    u.dest  = DST_TA;
    return u;
  endfunction

  function automatic uop_t mk_next();
    uop_t u;
    u.kind  = UOP_NEXT;
    u.src_a = SRC_TA;
    u.src_b = SRC_TB;
    u.coef  = COEF_X;
    u.shift = SH_0;
    u.dest  = DST_TA;
    return u;
  endfunction

  // Micro-programme for one step of the recurrence of each family.
  function automatic uop_t uop_lookup(logic [2:0] fam, logic [STEP_W-1:0] step);
    uop_t u;
    u = mk_next();
    if (step == '0) begin
      u = mk_mul(SRC_CUR, COEF_X, SH_24, DST_XP);
    end else begin
      case (fam)
        FAM_LEGENDRE: begin
          case (step)
            3'd1:    u = mk_mul(SRC_XP, COEF_2KP1, SH_0, DST_TA);
            3'd2:    u = mk_mul(SRC_PREV, COEF_K, SH_0, DST_TB);
            3'd3:    u = mk_sub(SRC_TA, SRC_TB);
            3'd4:    u = mk_mul(SRC_TA, COEF_RECIP, SH_32, DST_TA);
            default: u = mk_next();
          endcase
        end
        FAM_LAGUERRE: begin
          case (step)
            3'd1:    u = mk_mul(SRC_CUR, COEF_2KP1, SH_0, DST_TA);
            3'd2:    u = mk_sub(SRC_XP, SRC_TA);
            3'd3:    u = mk_mul(SRC_PREV, COEF_KK, SH_0, DST_TB);
            3'd4:    u = mk_sub(SRC_TA, SRC_TB);
            default: u = mk_next();
          endcase
        end
        FAM_HERMITE: begin
          case (step)
            3'd1:    u = mk_mul(SRC_XP, COEF_TWO, SH_0, DST_TA);
            3'd2:    u = mk_mul(SRC_PREV, COEF_2K, SH_0, DST_TB);
            3'd3:    u = mk_sub(SRC_TA, SRC_TB);
            default: u = mk_next();
          endcase
        end
        default: begin
          case (step)
            3'd1:    u = mk_mul(SRC_XP, COEF_TWO, SH_0, DST_TA);
            3'd2:    u = mk_sub(SRC_TA, SRC_PREV);
            default: u = mk_next();
          endcase
        end
      endcase
    end
    return u;
  endfunction

endpackage

/* design/orthogonal_polynomial_eval.sv */
// Evaluates a Legendre, monic Laguerre, Hermite or Chebyshev polynomial of
// a requested degree at a Q8.24 argument and returns a saturated Q32.32 value.
// Requests arrive on the in_valid/in_ready channel; a transfer carries
// req_type, degree and x_value. Results leave on the out_valid/out_ready
// channel as poly_value and overflow, one per request, in request order.
// The block works on one request at a time. A request of degree n runs the
// recurrence n - 1 times; degree 0 or 1 and unused family codes skip it.
// Every product of the recurrence goes through the single 32 by 32
// multiplier. The result waits in an output register, so the next request
// is taken while it is still held; if the receiver stalls, the following
// result waits in the datapath, with the controller in its finish state,
// until the register frees.
// Reset empties the output register and returns the controller to idle.
module orthogonal_polynomial_eval #(
  parameter int MAX_DEGREE = opeval_pkg::MAX_DEGREE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          req_type,
  input  logic [4:0]          degree,
  input  logic signed [31:0]  x_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  poly_value,
  output logic                overflow
);
  import opeval_pkg::*;

  cmd_t cmd;
  sts_t sts;

  opeval_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  opeval_dp #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req_type),
    .degree     (degree),
    .x_value    (x_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .poly_value (poly_value),
    .overflow   (overflow)
  );

endmodule

/* design/opeval_mul.sv */
module opeval_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [63:0]          a,
  input  logic [31:0]          b_mag,
  input  logic                 b_neg,
  input  opeval_pkg::shift_t   shift,
  output logic                 done,
  output logic [63:0]          res,
  output logic                 ovf
);
  import opeval_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LO   = 5'b00010,
    M_HI   = 5'b00100,
    M_ADD  = 5'b01000,
    M_SAT  = 5'b10000
  } mstate_t;

  mstate_t     state;
  mstate_t     state_next;
  logic [63:0] ma;
  logic [31:0] mb;
  logic        neg;
  shift_t      sh;
  logic [63:0] pl;
  logic [64:0] plh;
  logic [63:0] ph;
  logic [63:0] m;
  logic        m_hi;

  logic [31:0] mul_lhs;
  logic [63:0] prod;
  logic [64:0] half;
  logic [64:0] sum;
  logic [96:0] full;
  logic [63:0] m_sel;
  logic        m_hi_sel;

  assign mul_lhs = (state == M_LO) ? ma[31:0] : ma[63:32];
  assign prod    = mul_lhs * mb;

  always_comb begin
    case (sh)
      SH_24:   half = 65'd1 << 23;
      SH_32:   half = 65'd1 << 31;
      default: half = '0;
    endcase
  end

  assign sum  = {1'b0, ph} + {32'd0, plh[64:32]};
  assign full = {sum, plh[31:0]};

  always_comb begin
    case (sh)
      SH_24: begin
        m_sel    = full[87:24];
        m_hi_sel = |full[96:88];
      end
      SH_32: begin
        m_sel    = full[95:32];
        m_hi_sel = full[96];
      end
      default: begin
        m_sel    = full[63:0];
        m_hi_sel = |full[96:64];
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE:  if (go) state_next = M_LO;
      M_LO:    state_next = M_HI;
      M_HI:    state_next = M_ADD;
      M_ADD:   state_next = M_SAT;
      M_SAT:   state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (go) begin
          ma  <= a[63] ? (64'd0 - a) : a;
          mb  <= b_mag;
          neg <= a[63] ^ b_neg;
          sh  <= shift;
        end
      end
      M_LO: begin
        pl <= prod;
      end
      M_HI: begin
        ph  <= prod;
        plh <= {1'b0, pl} + half;
      end
      M_ADD: begin
        m    <= m_sel;
        m_hi <= m_hi_sel;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (neg) begin
      ovf = m_hi | (m[63] & (|m[62:0]));
      res = ovf ? VAL_MIN : (64'd0 - m);
    end else begin
      ovf = m_hi | m[63];
      res = ovf ? VAL_MAX : m;
    end
  end

  assign done = (state == M_SAT);

  a_go_done: assert property (@(posedge clk) disable iff (rst)
    (go && state == M_IDLE) |-> ##4 done)
    else $error("multiplier result not ready four cycles after start");

endmodule

/* design/opeval_dp.sv */
module opeval_dp #(
  parameter int MAX_DEGREE = opeval_pkg::MAX_DEGREE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  opeval_pkg::cmd_t    cmd,
  output opeval_pkg::sts_t    sts,
  input  logic [2:0]          req_type,
  input  logic [4:0]          degree,
  input  logic signed [31:0]  x_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  poly_value,
  output logic                overflow
);
  import opeval_pkg::*;

  localparam int KW = $clog2(MAX_DEGREE + 1);

  logic [2:0]        fam;
  logic [KW-1:0]     n;
  logic [KW-1:0]     k;
  logic [31:0]       xs;
  logic [63:0]       prev;
  logic [63:0]       cur;
  logic [63:0]       xp;
  logic [63:0]       ta;
  logic [63:0]       tb;
  logic [STEP_W-1:0] step;
  logic              ov;

  logic [31:0]       recip_tbl [MAX_DEGREE+1];
  uop_t              uop;
  logic [63:0]       op_a;
  logic [63:0]       op_b;
  logic [31:0]       xs_mag;
  logic [31:0]       b_mag;
  logic              b_neg;
  logic [2*KW-1:0]   k_sq;
  logic [KW-1:0]     k_inc;
  logic [64:0]       diff;
  logic              sub_ov;
  logic [63:0]       sub_res;
  logic              mul_done;
  logic [63:0]       mul_res;
  logic              mul_ovf;
  logic [63:0]       xq;
  logic [63:0]       cur_init;
  logic [KW-1:0]     n_clamp;

  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_recip
    localparam longint unsigned Div = (g < 2) ? 2 : g;
    localparam longint unsigned RecipVal = ((64'd1 << 32) + Div / 2) / Div;
    assign recip_tbl[g] = RecipVal[31:0];
  end

  assign uop    = uop_lookup(fam, step);
  assign k_sq   = k * k;
  assign k_inc  = k + KW'(1);
  assign xs_mag = xs[31] ? (32'd0 - xs) : xs;

  always_comb begin
    case (uop.src_a)
      SRC_CUR:  op_a = cur;
      SRC_PREV: op_a = prev;
      SRC_XP:   op_a = xp;
      SRC_TA:   op_a = ta;
      SRC_TB:   op_a = tb;
      default:  op_a = cur;
    endcase
  end

  always_comb begin
    case (uop.src_b)
      SRC_CUR:  op_b = cur;
      SRC_PREV: op_b = prev;
      SRC_XP:   op_b = xp;
      SRC_TA:   op_b = ta;
      SRC_TB:   op_b = tb;
      default:  op_b = tb;
    endcase
  end

  always_comb begin
    b_neg = 1'b0;
    case (uop.coef)
      COEF_X: begin
        b_mag = xs_mag;
        b_neg = xs[31];
      end
      COEF_2KP1:  b_mag = 32'({k, 1'b1});
      COEF_K:     b_mag = 32'(k);
      COEF_KK:    b_mag = 32'(k_sq);
      COEF_TWO:   b_mag = 32'd2;
      COEF_2K:    b_mag = 32'({k, 1'b0});
      COEF_RECIP: b_mag = recip_tbl[k_inc];
      default:    b_mag = 32'd0;
    endcase
  end

  assign diff    = {op_a[63], op_a} - {op_b[63], op_b};
  assign sub_ov  = diff[64] != diff[63];
  assign sub_res = sub_ov ? (op_a[63] ? VAL_MIN : VAL_MAX) : diff[63:0];

  opeval_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .go    (cmd.mul_go),
    .a     (op_a),
    .b_mag (b_mag),
    .b_neg (b_neg),
    .shift (uop.shift),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  assign xq = {{24{x_value[31]}}, x_value, 8'd0};

  always_comb begin
    case (req_type)
      FAM_LAGUERRE: cur_init = xq - Q_ONE;
      FAM_HERMITE:  cur_init = {xq[62:0], 1'b0};
      FAM_CHEB2:    cur_init = {xq[62:0], 1'b0};
      default:      cur_init = xq;
    endcase
  end

  assign n_clamp = (32'(degree) > 32'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(degree);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fam  <= req_type;
      xs   <= x_value;
      prev <= Q_ONE;
      k    <= KW'(1);
      step <= '0;
      ov   <= 1'b0;
      if (req_type > FAM_CHEB2) begin
        cur <= '0;
        n   <= '0;
      end else if (degree == 5'd0) begin
        cur <= Q_ONE;
        n   <= '0;
      end else begin
        cur <= cur_init;
        n   <= n_clamp;
      end
    end
    if (cmd.sub_en) begin
      ta   <= sub_res;
      ov   <= ov | sub_ov;
      step <= step + STEP_W'(1);
    end
    if (cmd.mul_wr) begin
      case (uop.dest)
        DST_XP:  xp <= mul_res;
        DST_TA:  ta <= mul_res;
        DST_TB:  tb <= mul_res;
        default: begin
        end
      endcase
      ov   <= ov | mul_ovf;
      step <= step + STEP_W'(1);
    end
    if (cmd.adv) begin
      prev <= cur;
      cur  <= ta;
      k    <= k_inc;
      step <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      poly_value <= cur;
      overflow   <= ov;
    end
  end

  assign sts.kind      = uop.kind;
  assign sts.loop_done = k >= n;
  assign sts.mul_done  = mul_done;
  assign sts.out_free  = !out_valid || out_ready;

  a_deliver_free: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (!out_valid || out_ready))
    else $error("result written over one not yet transferred");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.adv |=> (k <= n))
    else $error("recurrence index ran past the degree");

endmodule

/* design/opeval_ctrl.sv */
module opeval_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  opeval_pkg::sts_t  sts,
  output opeval_pkg::cmd_t  cmd
);
  import opeval_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_MWAIT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.loop_done) begin
          state_next = S_FINISH;
        end else begin
          case (sts.kind)
            UOP_MUL: begin
              cmd.mul_go = 1'b1;
              state_next = S_MWAIT;
            end
            UOP_SUB:  cmd.sub_en = 1'b1;
            UOP_NEXT: cmd.adv = 1'b1;
            default:  cmd.adv = 1'b1;
          endcase
        end
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          cmd.mul_wr = 1'b1;
          state_next = S_RUN;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

endmodule
